/* sv/rc4_pkg.sv */
// shared types, operation codes and constants for the rc4 stream cipher
package rc4_pkg;

	localparam int SBOX_DEPTH = 256;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int KEY_LEN_W = 6;

	typedef logic [7:0] byte_t;
	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [3:0] op_t;

	localparam cfg_index_t REG_KEY_LENGTH = 3'd0;
	localparam cfg_index_t REG_KEY_WORD0 = 3'd1;

	localparam op_t OP_IDLE = 4'd0;
	localparam op_t OP_FILL = 4'd1;
	localparam op_t OP_KRD = 4'd2;
	localparam op_t OP_KRJ = 4'd3;
	localparam op_t OP_KWN = 4'd4;
	localparam op_t OP_KWJ = 4'd5;
	localparam op_t OP_GRI = 4'd6;
	localparam op_t OP_GRJ = 4'd7;
	localparam op_t OP_GWI = 4'd8;
	localparam op_t OP_GWJ = 4'd9;
	localparam op_t OP_GOUT = 4'd10;

	typedef struct packed {
		op_t  op;
		logic capture;
		logic emit;
	} rc4_cmd_t;

	typedef struct packed {
		logic count_last;
	} rc4_stat_t;

endpackage

/* sv/rc4_ctrl.sv */
// controller state machine: sequences key schedule and keystream steps
module rc4_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             rekey,
	input  logic             out_ready,
	input  rc4_pkg::rc4_stat_t stat,
	output logic             in_ready,
	output logic             out_valid,
	output rc4_pkg::rc4_cmd_t  cmd
);
	import rc4_pkg::*;

	op_t  state_q;
	op_t  state_d;
	logic scheduled_q;
	logic out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd.op = state_q;
		cmd.capture = 1'b0;
		cmd.emit = 1'b0;
		unique case (state_q)
			OP_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = (rekey || !scheduled_q) ? OP_FILL : OP_GRI;
				end
			end
			OP_FILL: begin
				if (stat.count_last) begin
					state_d = OP_KRD;
				end
			end
			OP_KRD: state_d = OP_KRJ;
			OP_KRJ: state_d = OP_KWN;
			OP_KWN: state_d = OP_KWJ;
			OP_KWJ: state_d = stat.count_last ? OP_GRI : OP_KRD;
			OP_GRI: state_d = OP_GRJ;
			OP_GRJ: state_d = OP_GWI;
			OP_GWI: state_d = OP_GWJ;
			OP_GWJ: state_d = OP_GOUT;
			OP_GOUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d = OP_IDLE;
				end
			end
			default: state_d = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= OP_IDLE;
			scheduled_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == OP_KWJ && stat.count_last) begin
				scheduled_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready = (state_q == OP_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* sv/rc4_dp.sv */
// datapath: key registers, s-box memory, indices and output word register
module rc4_dp #(
	parameter int KEY_MAX_BYTES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  rc4_pkg::cfg_index_t cfg_index,
	input  rc4_pkg::cfg_data_t  cfg_data,
	input  rc4_pkg::byte_t      data_byte,
	input  logic                final_in,
	input  rc4_pkg::rc4_cmd_t   cmd,
	output rc4_pkg::rc4_stat_t  stat,
	output rc4_pkg::byte_t      result_byte,
	output logic                final_out
);
	import rc4_pkg::*;

	localparam int KEY_WORDS = (KEY_MAX_BYTES + 7) / 8;
	localparam int KIDX_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

	logic [KEY_LEN_W-1:0]    key_length_q;
	logic [KEY_WORDS*64-1:0] key_q;
	logic [KIDX_W-1:0]       kidx_q;
	logic [KEY_LEN_W-1:0]    len_eff;
	logic                    kidx_last;
	byte_t                   key_byte;

	byte_t sbox_mem [SBOX_DEPTH];
	byte_t rdata_q;
	logic  we;
	logic  re;
	byte_t waddr;
	byte_t wdata;
	byte_t raddr;

	byte_t n_q;
	byte_t i_q;
	byte_t j_q;
	byte_t si_q;
	byte_t sj_q;
	logic  byp_q;
	byte_t data_q;
	logic  final_q;
	byte_t result_q;
	logic  final_out_q;
	byte_t kj_new;
	byte_t ks_addr;
	byte_t ks;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= 6'd16;
			key_q <= '0;
		end else if (cfg_write) begin
			if (cfg_index == REG_KEY_LENGTH) begin
				key_length_q <= cfg_data[KEY_LEN_W-1:0];
			end
			for (int w = 0; w < KEY_WORDS; w++) begin
				if (cfg_index == REG_KEY_WORD0 + cfg_index_t'(w)) begin
					key_q[w*64 +: 64] <= cfg_data;
				end
			end
		end
	end

	always_comb begin
		if (key_length_q == '0) begin
			len_eff = KEY_LEN_W'(1);
		end else if (key_length_q > KEY_LEN_W'(KEY_MAX_BYTES)) begin
			len_eff = KEY_LEN_W'(KEY_MAX_BYTES);
		end else begin
			len_eff = key_length_q;
		end
	end

	assign kidx_last = (KEY_LEN_W'(kidx_q) == len_eff - KEY_LEN_W'(1));
	assign key_byte = key_q[{kidx_q, 3'b000} +: 8];
	assign kj_new = j_q + rdata_q + key_byte;
	assign ks_addr = si_q + sj_q;
	assign ks = byp_q ? si_q : rdata_q;

	// memory port control
	always_comb begin
		we = 1'b0;
		re = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = '0;
		unique case (cmd.op)
			OP_FILL: begin
				we = 1'b1;
				waddr = n_q;
				wdata = n_q;
			end
			OP_KRD: begin
				re = 1'b1;
				raddr = n_q;
			end
			OP_KRJ: begin
				re = 1'b1;
				raddr = kj_new;
			end
			OP_KWN: begin
				we = 1'b1;
				waddr = n_q;
				wdata = rdata_q;
			end
			OP_KWJ: begin
				we = 1'b1;
				waddr = j_q;
				wdata = si_q;
			end
			OP_GRI: begin
				re = 1'b1;
				raddr = i_q + 8'd1;
			end
			OP_GRJ: begin
				re = 1'b1;
				raddr = j_q + rdata_q;
			end
			OP_GWI: begin
				we = 1'b1;
				waddr = i_q;
				wdata = rdata_q;
			end
			OP_GWJ: begin
				we = 1'b1;
				waddr = j_q;
				wdata = si_q;
				re = 1'b1;
				raddr = ks_addr;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// s-box memory
	always_ff @(posedge clk) begin
		if (we) begin
			sbox_mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= sbox_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			kidx_q <= '0;
		end else begin
			if (cmd.capture) begin
				n_q <= '0;
			end
			case (cmd.op)
				OP_FILL: begin
					n_q <= n_q + 8'd1;
					j_q <= '0;
					kidx_q <= '0;
				end
				OP_KRJ: j_q <= kj_new;
				OP_KWJ: begin
					n_q <= n_q + 8'd1;
					kidx_q <= kidx_last ? '0 : kidx_q + 1'b1;
					if (stat.count_last) begin
						i_q <= '0;
						j_q <= '0;
					end
				end
				OP_GRI: i_q <= i_q + 8'd1;
				OP_GRJ: j_q <= j_q + rdata_q;
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			data_q <= data_byte;
			final_q <= final_in;
		end
		if (cmd.op == OP_KRJ || cmd.op == OP_GRJ) begin
			si_q <= rdata_q;
		end
		if (cmd.op == OP_GWI) begin
			sj_q <= rdata_q;
		end
		if (cmd.op == OP_GWJ) begin
			// keystream read collides with the write of s[j]
			byp_q <= (ks_addr == j_q);
		end
		if (cmd.emit) begin
			result_q <= data_q ^ ks;
			final_out_q <= final_q;
		end
	end

	assign stat.count_last = (n_q == 8'hFF);
	assign result_byte = result_q;
	assign final_out = final_out_q;

endmodule

/* sv/rc4_stream_cipher.sv */
// RC4 stream cipher: each input word leaves XORed with the next keystream byte, so the
// same block encrypts and decrypts. The key (1 to KEY_MAX_BYTES bytes, length from
// key_length, zero read as one, larger values saturated) is taken from the configuration
// registers when the key schedule runs: on the first word after reset and on any word
// with rekey set; key writes made later only act at the next schedule. The s-box is a
// 256-entry memory with one read and one write port, and every step goes through it: a
// keyed word goes from one acceptance to the next through the accepting state, read
// s[i], read s[j], two swap writes with the keystream read beside the second, then the
// output load, and the output load waits while the previous word is still unaccepted.
// A key schedule runs in front of its word: it loads the identity, then swaps each entry
// s[n] with s[j]. A finished word waits in an output register while the next word is
// accepted. final_out copies final_in; it does not restart the stream.
module rc4_stream_cipher #(
	parameter int KEY_MAX_BYTES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  rc4_pkg::cfg_index_t cfg_index,
	input  rc4_pkg::cfg_data_t  cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  rc4_pkg::byte_t      data_byte,
	input  logic                rekey,
	input  logic                final_in,
	output logic                out_valid,
	input  logic                out_ready,
	output rc4_pkg::byte_t      result_byte,
	output logic                final_out
);
	import rc4_pkg::*;

	rc4_cmd_t  cmd;
	rc4_stat_t stat;

	rc4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.rekey     (rekey),
		.out_ready (out_ready),
		.stat      (stat),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	rc4_dp #(
		.KEY_MAX_BYTES (KEY_MAX_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.data_byte   (data_byte),
		.final_in    (final_in),
		.cmd         (cmd),
		.stat        (stat),
		.result_byte (result_byte),
		.final_out   (final_out)
	);

`ifndef SYNTH
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op != OP_IDLE) |-> !in_ready)
		else $error("in_ready high while a word is in progress");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("output word loaded but out_valid low");

	a_schedule_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_KWJ && stat.count_last) |=> (cmd.op == OP_GRI))
		else $error("key schedule did not hand over to keystream step");

	a_rekey_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && rekey) |=> (cmd.op == OP_FILL))
		else $error("rekey word did not start the key schedule");
`endif

endmodule

/* tb/sv/rc4_stream_cipher_test.sv */
// self-checking testbench for the rc4 stream cipher with its own keystream predictor
module rc4_stream_cipher_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rc4_pkg::*;

	localparam int KEY_BYTES = 32;
	localparam int STALL_LIMIT = 8000;
	localparam int MISMATCH_PRINTS = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int NOISY_WORDS = 1400;
	localparam int TOTAL_WORDS = 1600;
	localparam cfg_index_t REG_KEY_WORD3 = cfg_index_t'(REG_KEY_WORD0 + 3);

	typedef struct packed {
		byte_t data_byte;
		logic  rekey;
		logic  final_in;
	} plain_word_t;

	typedef struct packed {
		byte_t result_byte;
		logic  final_out;
	} cipher_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_write = 1'b0;
	cfg_index_t cfg_index = '0;
	cfg_data_t  cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	byte_t      data_byte = '0;
	logic       rekey = 1'b0;
	logic       final_in = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	byte_t      result_byte;
	logic       final_out;

	rc4_stream_cipher u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.rekey      (rekey),
		.final_in   (final_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_byte(result_byte),
		.final_out  (final_out)
	);

	// predictor state
	byte_t        perm [SBOX_DEPTH];
	byte_t        pos_i = '0;
	byte_t        pos_j = '0;
	logic         keyed = 1'b0;
	logic [5:0]   key_len = 6'd16;
	cfg_data_t    key_words [4] = '{default: '0};

	plain_word_t  plain_q [$];
	cipher_word_t ciphered_q [$];
	int           queued_cnt = 0;
	int           taken_cnt = 0;
	int           results_seen = 0;
	int           mismatches = 0;
	int           stall_cycles = 0;
	logic         in_acc = 1'b0;
	bit           idle_on = 1'b1;
	int           in_gap = 0;
	int           out_gap = 0;
	int           hold_left = 0;
	bit           held_once = 1'b0;

	function automatic void schedule_key();
		int    len;
		int    b;
		byte_t acc;
		byte_t t;
		len = key_len;
		if (len < 1) len = 1;
		if (len > KEY_BYTES) len = KEY_BYTES;
		for (int n = 0; n < SBOX_DEPTH; n++) perm[n] = byte_t'(n);
		acc = '0;
		for (int n = 0; n < SBOX_DEPTH; n++) begin
			b = n % len;
			acc = byte_t'(acc + perm[n] + key_words[b / 8][(b % 8) * 8 +: 8]);
			t = perm[n];
			perm[n] = perm[acc];
			perm[acc] = t;
		end
		pos_i = '0;
		pos_j = '0;
		keyed = 1'b1;
	endfunction

	function automatic byte_t keystream_byte(logic restart);
		byte_t t;
		if (restart || !keyed) schedule_key();
		pos_i = byte_t'(pos_i + 8'd1);
		pos_j = byte_t'(pos_j + perm[pos_i]);
		t = perm[pos_i];
		perm[pos_i] = perm[pos_j];
		perm[pos_j] = t;
		return perm[byte_t'(perm[pos_i] + perm[pos_j])];
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	// driver: word source
	always @(negedge clk) begin
		plain_word_t nxt;
		if (!in_valid || in_acc) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap = in_gap - 1;
			end else if (plain_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				in_valid <= 1'b0;
				in_gap = $urandom_range(0, 4);
			end else begin
				nxt = plain_q.pop_front();
				in_valid <= 1'b1;
				data_byte <= nxt.data_byte;
				rekey <= nxt.rekey;
				final_in <= nxt.final_in;
			end
		end
	end

	// result sink with one long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (!held_once && results_seen >= 60 && plain_q.size() > 2) begin
			held_once = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_ready <= 1'b0;
			out_gap = out_gap - 1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			out_gap = $urandom_range(0, 4);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor: predicts on input acceptance, checks on output acceptance
	always @(posedge clk) begin
		cipher_word_t want;
		byte_t        ks;
		if (arst_n) begin
			in_acc <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				ks = keystream_byte(rekey);
				want.result_byte = data_byte ^ ks;
				want.final_out = final_in;
				ciphered_q.push_back(want);
				taken_cnt++;
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (ciphered_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MISMATCH_PRINTS)
						$display("%0t: unexpected word expected none got %02h/%0b",
							$time, result_byte, final_out);
				end else begin
					want = ciphered_q.pop_front();
					if (result_byte !== want.result_byte) begin
						mismatches++;
						if (mismatches <= MISMATCH_PRINTS)
							$display("%0t: result_byte expected %02h got %02h",
								$time, want.result_byte, result_byte);
					end
					if (final_out !== want.final_out) begin
						mismatches++;
						if (mismatches <= MISMATCH_PRINTS)
							$display("%0t: final_out expected %0b got %0b",
								$time, want.final_out, final_out);
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic write_reg(cfg_index_t idx, cfg_data_t val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_KEY_LENGTH)
			key_len = val[5:0];
		else if (idx >= REG_KEY_WORD0 && idx <= REG_KEY_WORD3)
			key_words[idx - REG_KEY_WORD0] = val;
	endtask

	task automatic queue_word(byte_t d, logic rk, logic fn);
		plain_word_t w;
		w.data_byte = d;
		w.rekey = rk;
		w.final_in = fn;
		plain_q.push_back(w);
		queued_cnt++;
	endtask

	task automatic wait_drained();
		while (taken_cnt != queued_cnt || ciphered_q.size() != 0) @(negedge clk);
	endtask

	function automatic cfg_data_t random_data();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic random_key();
		logic [5:0] len;
		case ($urandom_range(0, 5))
			0: len = 6'd1;
			1: len = 6'd32;
			2: len = 6'($urandom_range(0, 63));
			default: len = 6'($urandom_range(1, 32));
		endcase
		write_reg(REG_KEY_LENGTH, {$urandom, $urandom} & ~cfg_data_t'(6'h3f) | len);
		for (int w = 0; w < 4; w++)
			if ($urandom_range(0, 3) != 0)
				write_reg(cfg_index_t'(REG_KEY_WORD0 + w), random_data());
		if ($urandom_range(0, 3) == 0)
			write_reg(cfg_index_t'(REG_KEY_WORD3 + $urandom_range(1, 3)), random_data());
	endtask

	// a message: usually rekey on its first word and final on its last, with some noise
	task automatic queue_message(int limit);
		int   len;
		bit   fresh;
		logic rk;
		logic fn;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 400) : $urandom_range(1, 40);
		if (len > limit - queued_cnt) len = limit - queued_cnt;
		fresh = $urandom_range(0, 7) != 0;
		for (int k = 0; k < len; k++) begin
			rk = (k == 0) ? fresh : 1'b0;
			fn = (k == len - 1) ? ($urandom_range(0, 7) != 0) : 1'b0;
			if ($urandom_range(0, 31) == 0) begin
				rk = 1'($urandom_range(0, 1));
				fn = 1'($urandom_range(0, 1));
			end
			queue_word(byte_t'($urandom_range(0, 255)), rk, fn);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// first word after reset keys with the reset key
		queue_word(8'h00, 1'b0, 1'b0);
		queue_word(8'hff, 1'b0, 1'b0);
		queue_word(8'h5a, 1'b0, 1'b1);
		wait_drained();

		// zero length reads as one, writes past the last key word are dropped
		write_reg(REG_KEY_LENGTH, {58'h2aa_aaaa_aaaa_aaaa, 6'd0});
		write_reg(REG_KEY_WORD0, {$urandom, $urandom});
		for (int k = 1; k <= 3; k++)
			write_reg(cfg_index_t'(REG_KEY_WORD3 + k), '1);
		queue_word(8'h00, 1'b1, 1'b0);
		queue_word(8'hff, 1'b0, 1'b0);
		queue_word(8'h3c, 1'b0, 1'b1);
		wait_drained();

		// longest key, all ones, back-to-back rekey
		write_reg(REG_KEY_LENGTH, cfg_data_t'(32));
		for (int w = 0; w < 4; w++) write_reg(cfg_index_t'(REG_KEY_WORD0 + w), '1);
		queue_word(8'hff, 1'b1, 1'b0);
		queue_word(8'h00, 1'b1, 1'b0);
		queue_word(8'h81, 1'b0, 1'b1);
		wait_drained();

		// oversize length saturates
		write_reg(REG_KEY_LENGTH, '1);
		for (int w = 0; w < 4; w++)
			write_reg(cfg_index_t'(REG_KEY_WORD0 + w), {$urandom, $urandom});
		queue_word(8'h7e, 1'b1, 1'b0);
		queue_word(8'he7, 1'b0, 1'b1);
		wait_drained();

		// key change while keyed waits for rekey; final does not restart
		write_reg(REG_KEY_LENGTH, cfg_data_t'(5));
		write_reg(REG_KEY_WORD0, {$urandom, $urandom});
		queue_word(8'h11, 1'b0, 1'b1);
		queue_word(8'h22, 1'b0, 1'b0);
		queue_word(8'h33, 1'b1, 1'b0);
		queue_word(8'h44, 1'b0, 1'b1);
		wait_drained();

		// single byte key
		write_reg(REG_KEY_LENGTH, cfg_data_t'(1));
		write_reg(REG_KEY_WORD0, '0);
		queue_word(8'haa, 1'b1, 1'b1);
		queue_word(8'h55, 1'b0, 1'b1);
		queue_word(8'h00, 1'b0, 1'b0);
		wait_drained();

		while (queued_cnt < NOISY_WORDS) begin
			if ($urandom_range(0, 3) == 0) begin
				wait_drained();
				random_key();
			end
			queue_message(NOISY_WORDS);
		end
		wait_drained();
		idle_on = 1'b0;
		while (queued_cnt < TOTAL_WORDS) queue_message(TOTAL_WORDS);
		wait_drained();
		repeat (20) @(negedge clk);

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* filelist.f */
sv/rc4_pkg.sv
sv/rc4_ctrl.sv
sv/rc4_dp.sv
sv/rc4_stream_cipher.sv
tb/sv/rc4_stream_cipher_test.sv
